[src/w3f_pkg.sv]
// shared constants and types for the 3x3 mean / median window filter
package w3f_pkg;

  localparam int PIX_W         = 8;
  localparam int WIN_N         = 9;
  localparam int CNT_W         = 4;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int ROW_W         = 17;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd2;

  localparam logic [CFG_WIDTH_W-1:0]  RST_WIDTH  = 11'd1024;
  localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT = 16'd1024;

  localparam logic REQ_FLUSH   = 1'b1;
  localparam logic MODE_MEAN   = 1'b0;
  localparam logic MODE_MEDIAN = 1'b1;

  // sum of nine pixels, and x/9 as (x * 7282) >> 16, exact for x below 2304
  localparam int SUM_W      = 12;
  localparam int RECIP_W    = 13;
  localparam int PROD_W     = SUM_W + RECIP_W;
  localparam int MEAN_SHIFT = 16;
  localparam logic [RECIP_W-1:0] MEAN_RECIP = 13'd7282;

  // decisions made when a request is taken
  typedef struct packed {
    logic             emit;
    logic             row_start;
    logic             last;
    logic             mode;
    logic [WIN_N-1:0] mask;
    logic             top_en;
    logic             mid_en;
  } w3f_ctl_t;

  // one filter job: window snapshot and the in-image neighbours
  typedef struct packed {
    logic [WIN_N-1:0][PIX_W-1:0] pix;
    logic [WIN_N-1:0]            mask;
    logic                        mode;
    logic                        last;
  } w3f_job_t;

endpackage

[src/w3f_linebuf.sv]
// two line stores sharing one address, registered read with write forwarding
module w3f_linebuf import w3f_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [PIX_W-1:0]         wr_above,
  input  logic [PIX_W-1:0]         wr_two,
  output logic [PIX_W-1:0]         rd_above,
  output logic [PIX_W-1:0]         rd_two
);

  logic [PIX_W-1:0] line_above_mem [DEPTH];
  logic [PIX_W-1:0] line_two_mem   [DEPTH];

  logic [PIX_W-1:0] q_above_r;
  logic [PIX_W-1:0] q_two_r;
  logic [PIX_W-1:0] fwd_above_r;
  logic [PIX_W-1:0] fwd_two_r;
  logic             fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_above_mem[wr_addr] <= wr_above;
      line_two_mem[wr_addr]   <= wr_two;
    end
    if (rd_en) begin
      q_above_r   <= line_above_mem[rd_addr];
      q_two_r     <= line_two_mem[rd_addr];
      fwd_above_r <= wr_above;
      fwd_two_r   <= wr_two;
    end
  end

  // a read that meets a write to the same column in the same cycle sees the new data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_above = fwd_r ? fwd_above_r : q_above_r;
  assign rd_two   = fwd_r ? fwd_two_r   : q_two_r;

endmodule

[src/w3f_window.sv]
// window stage: shifts the 3x3 window, writes the line stores back, builds filter jobs
module w3f_window import w3f_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  w3f_ctl_t                     ld_ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0] ld_addr,
  input  logic [PIX_W-1:0]             ld_bot,
  output logic                         ready,
  input  logic [PIX_W-1:0]             rd_above,
  input  logic [PIX_W-1:0]             rd_two,
  output logic                         wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  output logic [PIX_W-1:0]             wr_above,
  output logic [PIX_W-1:0]             wr_two,
  output logic                         job_valid,
  output w3f_job_t                     job,
  input  logic                         job_ready
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                        s1_v_r;
  w3f_ctl_t                    s1_ctl_r;
  logic [CW-1:0]               s1_addr_r;
  logic [PIX_W-1:0]            s1_bot_r;
  logic [WIN_N-1:0][PIX_W-1:0] win_r;
  logic [WIN_N-1:0][PIX_W-1:0] win_nxt;
  logic                        job_v_r;
  w3f_job_t                    job_r;
  logic                        s1_adv;
  logic [PIX_W-1:0]            top;
  logic [PIX_W-1:0]            mid;

  assign s1_adv = s1_v_r && (!s1_ctl_r.emit || !job_v_r || job_ready);
  assign ready  = !s1_v_r || s1_adv;

  assign top = s1_ctl_r.top_en ? rd_two   : '0;
  assign mid = s1_ctl_r.mid_en ? rd_above : '0;

  assign wr_en    = s1_adv;
  assign wr_addr  = s1_addr_r;
  assign wr_above = s1_bot_r;
  assign wr_two   = mid;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]     = win_r[r*3+1];
      win_nxt[r*3+1]   = win_r[r*3+2];
    end
    win_nxt[2] = top;
    win_nxt[5] = mid;
    win_nxt[8] = s1_bot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      job_v_r <= 1'b0;
      win_r   <= '0;
    end else begin
      if (load) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv && s1_ctl_r.emit) begin
        job_v_r <= 1'b1;
      end else if (job_ready) begin
        job_v_r <= 1'b0;
      end
      if (s1_adv) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_ctl_r  <= ld_ctl;
      s1_addr_r <= ld_addr;
      s1_bot_r  <= ld_bot;
    end
    // the row-start result belongs to the window before this shift
    if (s1_adv && s1_ctl_r.emit) begin
      job_r.pix  <= s1_ctl_r.row_start ? win_r : win_nxt;
      job_r.mask <= s1_ctl_r.mask;
      job_r.mode <= s1_ctl_r.mode;
      job_r.last <= s1_ctl_r.last;
    end
  end

  assign job_valid = job_v_r;
  assign job       = job_r;

endmodule

[src/w3f_kernel.sv]
// mean / median over the masked window, into the result register
module w3f_kernel import w3f_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  input  w3f_job_t         job,
  output logic             job_ready,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_pixel,
  output logic             out_last,
  input  logic             out_ready
);

  logic                   o_v_r;
  logic [PIX_W-1:0]       o_pix_r;
  logic                   o_last_r;
  logic [SUM_W-1:0]       sum;
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       rank [WIN_N];
  logic [PIX_W-1:0]       med;
  logic [PROD_W-1:0]      prod;
  logic [PIX_W-1:0]       mean;
  logic [PIX_W-1:0]       res;
  logic                   take;

  assign job_ready = !o_v_r || out_ready;
  assign take      = job_valid && job_ready;

  always_comb begin
    sum = '0;
    cnt = '0;
    for (int i = 0; i < WIN_N; i++) begin
      if (job.mask[i]) begin
        sum = sum + SUM_W'(job.pix[i]);
        cnt = cnt + CNT_W'(1);
      end
    end
  end

  // rank of each neighbour, ties broken by position; the median has rank cnt/2
  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WIN_N; j++) begin
        if (job.mask[j] && ((job.pix[j] < job.pix[i]) ||
                            ((job.pix[j] == job.pix[i]) && (j < i)))) begin
          rank[i] = rank[i] + CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    med = '0;
    for (int i = 0; i < WIN_N; i++) begin
      if (job.mask[i] && (rank[i] == (cnt >> 1))) begin
        med = med | job.pix[i];
      end
    end
  end

  assign prod = PROD_W'(sum) * PROD_W'(MEAN_RECIP);
  assign mean = prod[MEAN_SHIFT +: PIX_W];
  assign res  = (job.mode == MODE_MEDIAN) ? med : mean;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (take) begin
      o_v_r <= 1'b1;
    end else if (out_ready) begin
      o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      o_pix_r  <= res;
      o_last_r <= job.last;
    end
  end

  assign out_valid = o_v_r;
  assign out_pixel = o_pix_r;
  assign out_last  = o_last_r;

endmodule

[src/window3x3_mean_median_filter.sv]
// top level: 3x3 mean / median filter over a raster pixel stream
//
//  channel  | ports                          | carries
//  ---------+--------------------------------+-------------------------------------
//  in       | in_tvalid/in_tready            | tdata: pixel_in, tuser: req_type
//  out      | out_tvalid/out_tready          | tdata: pixel_out, tlast: frame_end
//  cfg      | cfg_we/cfg_index/cfg_wdata     | 0 filter_mode, 1 image_width, 2 image_height
//
// one request per clock while in_tready is high; the result a request causes passes the
// window, job and result registers in turn, the line store read taking the first of these.
// results trail the pixels by image_width+1 positions; flush requests drain them.
// reset is synchronous; line stores are not cleared, rows above the image read as zero.
// a stall on out backs up through the job and window registers before in_tready drops.
module window3x3_mean_median_filter import w3f_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // [7:0] pixel_in
  input  logic                  in_tuser,   // [0] req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIX_W-1:0]      out_tdata,  // [7:0] pixel_out
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int LW = (WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W;

  logic                    filter_mode_r;
  logic [CFG_WIDTH_W-1:0]  image_width_r;
  logic [CFG_HEIGHT_W-1:0] image_height_r;
  logic [CW-1:0]           col_r;
  logic [ROW_W-1:0]        row_r;
  logic [CW-1:0]           col_nxt;
  logic [ROW_W-1:0]        row_nxt;

  logic [LW-1:0]    w_l;
  logic [WW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [ROW_W-1:0] h_p1;
  logic [CW-1:0]    c1;
  logic [ROW_W-1:0] r1;
  logic [CW-1:0]    c2;
  logic [ROW_W-1:0] r2;
  logic [WW-1:0]    c_inc;
  logic             flush;
  logic             flush_ign;
  logic [2:0]       rows_ok;
  logic [2:0]       cols_ok;
  w3f_ctl_t         ctl;
  logic [PIX_W-1:0] bot;
  logic             in_acc;
  logic             s1_load;
  logic             s1_ready;

  logic             wr_en;
  logic [CW-1:0]    wr_addr;
  logic [PIX_W-1:0] wr_above;
  logic [PIX_W-1:0] wr_two;
  logic [PIX_W-1:0] rd_above;
  logic [PIX_W-1:0] rd_two;
  logic             job_valid;
  logic             job_ready;
  w3f_job_t         job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r  <= MODE_MEAN;
      image_width_r  <= RST_WIDTH;
      image_height_r <= RST_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_MODE:   filter_mode_r  <= cfg_wdata[0];
        CFG_IDX_WIDTH:  image_width_r  <= cfg_wdata[CFG_WIDTH_W-1:0];
        CFG_IDX_HEIGHT: image_height_r <= cfg_wdata[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped frame size
  always_comb begin
    if (image_width_r == '0) begin
      w_l = LW'(1);
    end else if (LW'(image_width_r) > LW'(MAX_WIDTH)) begin
      w_l = LW'(MAX_WIDTH);
    end else begin
      w_l = LW'(image_width_r);
    end
    w_eff = w_l[WW-1:0];
    h_eff = (image_height_r == '0) ? ROW_W'(1) : ROW_W'(image_height_r);
    h_p1  = h_eff + ROW_W'(1);
  end

  assign flush  = (in_tuser == REQ_FLUSH);
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    // wrap a column left beyond a narrowed row, restart past the drain
    if (WW'(col_r) >= w_eff) begin
      c1 = '0;
      r1 = row_r + ROW_W'(1);
    end else begin
      c1 = col_r;
      r1 = row_r;
    end
    if ((r1 > h_p1) || ((r1 == h_p1) && (c1 != '0))) begin
      c2 = '0;
      r2 = '0;
    end else begin
      c2 = c1;
      r2 = r1;
    end
    flush_ign = flush && (r2 < h_eff);

    ctl.row_start = (c2 == '0) && (r2 >= ROW_W'(2));
    ctl.emit      = ctl.row_start || ((c2 != '0) && (r2 >= ROW_W'(1)) && (r2 <= h_eff));
    ctl.last      = ctl.row_start && (r2 == h_p1);
    ctl.mode      = filter_mode_r;
    ctl.top_en    = (r2 >= ROW_W'(2));
    ctl.mid_en    = (r2 >= ROW_W'(1));

    if (ctl.row_start) begin
      rows_ok = {r2 <= h_eff, 1'b1, r2 >= ROW_W'(3)};
      cols_ok = {1'b1, w_eff >= WW'(2), 1'b0};
    end else begin
      rows_ok = {r2 < h_eff, 1'b1, r2 >= ROW_W'(2)};
      cols_ok = {1'b1, 1'b1, c2 >= CW'(2)};
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        ctl.mask[r*3+k] = rows_ok[r] && cols_ok[k];
      end
    end

    bot = (!flush && (r2 < h_eff)) ? in_tdata : '0;

    c_inc = WW'(c2) + WW'(1);
    if (flush_ign) begin
      col_nxt = c2;
      row_nxt = r2;
    end else if (ctl.last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = r2 + ROW_W'(1);
    end else begin
      col_nxt = c_inc[CW-1:0];
      row_nxt = r2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign in_tready = s1_ready;
  assign s1_load   = in_acc && !flush_ign;

  w3f_linebuf #(
    .DEPTH(MAX_WIDTH)
  ) u_linebuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (s1_load),
    .rd_addr  (c2),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_above (wr_above),
    .wr_two   (wr_two),
    .rd_above (rd_above),
    .rd_two   (rd_two)
  );

  w3f_window #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_load),
    .ld_ctl    (ctl),
    .ld_addr   (c2),
    .ld_bot    (bot),
    .ready     (s1_ready),
    .rd_above  (rd_above),
    .rd_two    (rd_two),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_above  (wr_above),
    .wr_two    (wr_two),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  w3f_kernel u_kernel (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready),
    .out_valid (out_tvalid),
    .out_pixel (out_tdata),
    .out_last  (out_tlast),
    .out_ready (out_tready)
  );

endmodule

[verif/window3x3_mean_median_filter_tb.sv]
// self-checking testbench for the 3x3 mean / median window filter
`timescale 1ns / 100ps

module window3x3_mean_median_filter_tb;
  import w3f_pkg::*;

  localparam logic REQ_PIX       = ~REQ_FLUSH;
  localparam int   MAX_W         = DEF_MAX_WIDTH;
  localparam int   RAND_ITEMS    = 400;
  localparam int   SETTLE_CYCLES = 8;
  localparam int   TAIL_CYCLES   = 12;
  localparam int   QUIET_LIMIT   = 3000;
  localparam int   IDLE_PCT      = 21;

  typedef enum int {ROW_CFG, ROW_REQ} row_kind_t;
  typedef enum int {EXP_PRED, EXP_NONE, EXP_VAL} row_exp_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic                  flush;
    logic [CFG_DATA_W-1:0] val;
    row_exp_t              exp;
    logic [PIX_W-1:0]      exp_pix;
    logic                  exp_last;
  } stim_row_t;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             last;
  } filtered_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [PIX_W-1:0]      out_tdata;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  window3x3_mean_median_filter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] pixel_in
    .in_tuser   (in_tuser),   // [0] req_type
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] pixel_out
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [PIX_W-1:0]        line_a [MAX_W];
  logic [PIX_W-1:0]        line_b [MAX_W];
  logic [PIX_W-1:0]        win [WIN_N];
  int                      in_col;
  int                      in_row;
  logic                    cur_mode;
  logic [CFG_WIDTH_W-1:0]  cur_width;
  logic [CFG_HEIGHT_W-1:0] cur_height;
  logic                    pred_hit;
  logic                    frame_done;

  filtered_t filtered_q[$];
  filtered_t want;
  stim_row_t stim_rows[$];
  int        mismatches = 0;
  int        reqs_sent = 0;
  int        quiet = 0;
  bit        calm = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int exp_v);
    $display("%0t: mismatch on %s: got %0d, wanted %0d", $time, what, got, exp_v);
    mismatches++;
  endtask

  function automatic logic [PIX_W-1:0] window_result(input int cy, input int cx, input int base,
                                                     input int w, input int h);
    int vals[WIN_N];
    int cnt;
    int acc;
    int y;
    int x;
    int wc;
    int v;
    int j;
    cnt = 0;
    acc = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        y  = cy + dy;
        x  = cx + dx;
        wc = x - base;
        if (y >= 0 && y < h && x >= 0 && x < w && wc >= 0 && wc <= 2) begin
          vals[cnt] = win[(dy + 1) * 3 + wc];
          acc += vals[cnt];
          cnt++;
        end
      end
    end
    if (cur_mode == MODE_MEAN) return PIX_W'(acc / WIN_N);
    if (cnt == 0) return '0;
    for (int i = 1; i < cnt; i++) begin
      v = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > v) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = v;
    end
    return PIX_W'(vals[cnt / 2]);
  endfunction

  // advances the filter state by one accepted request, queues the filtered pixel it yields
  function automatic void predict_filtered(input logic flush, input logic [PIX_W-1:0] pix);
    int w;
    int h;
    int r;
    int c;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
    logic [PIX_W-1:0] res;
    logic last;
    pred_hit = 1'b0;
    last = 1'b0;
    res = '0;
    w = cur_width;
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    h = cur_height;
    if (h < 1) h = 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (in_row > h + 1 || (in_row == h + 1 && in_col > 0)) begin
      in_row = 0;
      in_col = 0;
    end
    // flush while pixels are still owed is dropped
    if (flush == REQ_FLUSH && in_row < h) return;
    r = in_row;
    c = in_col;
    // row start closes the last centre of the row two above
    if (c == 0 && r >= 2 && r - 2 < h) begin
      res = window_result(r - 2, w - 1, w - 3, w, h);
      last = (r - 2 == h - 1);
      pred_hit = 1'b1;
    end
    top = (r >= 2) ? line_b[c] : '0;
    mid = (r >= 1) ? line_a[c] : '0;
    bot = (flush != REQ_FLUSH && r < h) ? pix : '0;
    for (int i = 0; i < 3; i++) begin
      win[i*3]     = win[i*3 + 1];
      win[i*3 + 1] = win[i*3 + 2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = bot;
    line_b[c] = mid;
    line_a[c] = bot;
    if (c >= 1 && r >= 1 && r - 1 < h) begin
      res = window_result(r - 1, c - 1, c - 2, w, h);
      last = 1'b0;
      pred_hit = 1'b1;
    end
    if (pred_hit) filtered_q.push_back('{pix: res, last: last});
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    in_col = c;
    in_row = r;
    if (last) begin
      in_col = 0;
      in_row = 0;
      frame_done = 1'b1;
    end
  endfunction

  function automatic bit take_gap();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  task automatic send_req(input logic flush, input logic [PIX_W-1:0] pix);
    while (take_gap()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= flush;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_filtered(flush, pix);
    reqs_sent++;
  endtask

  // block drained: no result owed and the pipeline given time to empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_IDX_MODE:   cur_mode   = val[0];
      CFG_IDX_WIDTH:  cur_width  = val[CFG_WIDTH_W-1:0];
      CFG_IDX_HEIGHT: cur_height = val[CFG_HEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  // feeds pixels with occasional flushes until the frame is in, then flushes until frame_end is predicted
  task automatic run_frame();
    int fill;
    int h;
    logic [PIX_W-1:0] pix;
    fill = $urandom_range(9);
    frame_done = 1'b0;
    while (!frame_done) begin
      h = (cur_height == 0) ? 1 : int'(cur_height);
      if (fill == 0) pix = '0;
      else if (fill == 1) pix = '1;
      else pix = PIX_W'($urandom_range(255));
      if (in_row < h) begin
        if ($urandom_range(19) == 0) send_req(REQ_FLUSH, pix);
        else send_req(REQ_PIX, pix);
      end else begin
        // a stray pixel past the frame acts as a flush
        if ($urandom_range(9) == 0) send_req(REQ_PIX, PIX_W'($urandom_range(255)));
        else send_req(REQ_FLUSH, PIX_W'($urandom_range(255)));
      end
    end
  endtask

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    stim_rows.push_back('{ROW_CFG, idx, 1'b0, val, EXP_PRED, '0, 1'b0});
  endfunction

  function automatic void add_req(input logic flush, input logic [PIX_W-1:0] pix,
                                  input row_exp_t exp = EXP_PRED,
                                  input logic [PIX_W-1:0] exp_pix = '0,
                                  input logic exp_last = 1'b0);
    stim_rows.push_back('{ROW_REQ, '0, flush, CFG_DATA_W'(pix), exp, exp_pix, exp_last});
  endfunction

  // result checker and result-side stalls
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (filtered_q.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata, -1);
      end else begin
        want = filtered_q.pop_front();
        if (out_tdata !== want.pix) report_mismatch("pixel_out", out_tdata, want.pix);
        if (out_tlast !== want.last) report_mismatch("frame_end", out_tlast, want.last);
      end
    end
    out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("window3x3_mean_median_filter_tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int rand_start;
    logic [CFG_DATA_W-1:0] wv;
    logic [CFG_DATA_W-1:0] hv;

    for (int i = 0; i < MAX_W; i++) begin
      line_a[i] = '0;
      line_b[i] = '0;
    end
    for (int i = 0; i < WIN_N; i++) win[i] = '0;
    in_col     = 0;
    in_row     = 0;
    cur_mode   = MODE_MEAN;
    cur_width  = RST_WIDTH;
    cur_height = RST_HEIGHT;
    frame_done = 1'b0;

    // early flush after reset, zero sizes, single-pixel frames, stray pixel, 3x2 median
    add_req(REQ_FLUSH, 8'hAA, EXP_NONE);
    add_cfg(CFG_IDX_MODE, CFG_DATA_W'(MODE_MEAN));
    add_cfg(CFG_IDX_WIDTH, 16'd0);
    add_cfg(CFG_IDX_HEIGHT, 16'd0);
    add_req(REQ_PIX, 8'd255, EXP_NONE);
    add_req(REQ_FLUSH, 8'h00, EXP_NONE);
    add_req(REQ_FLUSH, 8'h00, EXP_VAL, 8'd28, 1'b1);
    add_req(REQ_PIX, 8'd0, EXP_NONE);
    add_req(REQ_PIX, 8'd77, EXP_NONE);
    add_req(REQ_FLUSH, 8'hFF, EXP_VAL, 8'd0, 1'b1);
    add_cfg(CFG_IDX_MODE, CFG_DATA_W'(MODE_MEDIAN));
    add_req(REQ_PIX, 8'd200, EXP_NONE);
    add_req(REQ_FLUSH, 8'h55, EXP_NONE);
    add_req(REQ_FLUSH, 8'h55, EXP_VAL, 8'd200, 1'b1);
    add_cfg(CFG_IDX_WIDTH, 16'hF803);
    add_cfg(CFG_IDX_HEIGHT, 16'd2);
    add_req(REQ_PIX, 8'd0);
    add_req(REQ_PIX, 8'd255);
    add_req(REQ_PIX, 8'd17);
    add_req(REQ_PIX, 8'd128);
    add_req(REQ_PIX, 8'd255);
    add_req(REQ_PIX, 8'd1);
    add_req(REQ_FLUSH, 8'h00);
    add_req(REQ_FLUSH, 8'h00);
    add_req(REQ_FLUSH, 8'h00);
    add_req(REQ_FLUSH, 8'h00);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(stim_rows[i].idx, stim_rows[i].val);
      end else begin
        send_req(stim_rows[i].flush, stim_rows[i].val[PIX_W-1:0]);
        if (stim_rows[i].exp != EXP_PRED) begin
          if (pred_hit) void'(filtered_q.pop_back());
          if (stim_rows[i].exp == EXP_VAL)
            filtered_q.push_back('{pix: stim_rows[i].exp_pix, last: stim_rows[i].exp_last});
        end
      end
    end

    // tallest frame, cut short by lowering the height mid-frame
    settle();
    write_reg(CFG_IDX_MODE, CFG_DATA_W'($urandom_range(1)));
    write_reg(CFG_IDX_WIDTH, 16'd1);
    write_reg(CFG_IDX_HEIGHT, 16'hFFFF);
    repeat (20) send_req(REQ_PIX, PIX_W'($urandom_range(255)));
    settle();
    write_reg(CFG_IDX_HEIGHT, 16'd3);
    run_frame();

    // narrower rows mid-frame wrap the column
    settle();
    write_reg(CFG_IDX_WIDTH, 16'd8);
    write_reg(CFG_IDX_HEIGHT, 16'd4);
    repeat (13) send_req(REQ_PIX, PIX_W'($urandom_range(255)));
    settle();
    write_reg(CFG_IDX_WIDTH, 16'd5);
    run_frame();

    // widest row, clamped from the top of the field, with no stalls on either side:
    // the row wraps at the clamp and the next requests close the first centres
    settle();
    write_reg(CFG_IDX_MODE, CFG_DATA_W'(MODE_MEDIAN));
    write_reg(CFG_IDX_WIDTH, 16'h07FF);
    write_reg(CFG_IDX_HEIGHT, 16'd1);
    calm = 1'b1;
    repeat (MAX_W + 3) send_req(REQ_PIX, PIX_W'($urandom_range(255)));
    calm = 1'b0;

    rand_start = reqs_sent;
    while (reqs_sent - rand_start < RAND_ITEMS) begin
      settle();
      case ($urandom_range(9))
        0:       wv = 16'd0;
        1:       wv = 16'd1;
        2:       wv = 16'd2;
        default: wv = CFG_DATA_W'($urandom_range(3, 12));
      endcase
      case ($urandom_range(9))
        0:       hv = 16'd0;
        1:       hv = 16'd1;
        default: hv = CFG_DATA_W'($urandom_range(2, 6));
      endcase
      write_reg(CFG_IDX_MODE, CFG_DATA_W'($urandom_range(1)));
      write_reg(CFG_IDX_WIDTH, wv);
      write_reg(CFG_IDX_HEIGHT, hv);
      repeat ($urandom_range(1, 3)) run_frame();
    end

    in_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("window3x3_mean_median_filter_tb: PASS");
    end else begin
      $display("window3x3_mean_median_filter_tb: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
src/w3f_pkg.sv
src/w3f_linebuf.sv
src/w3f_window.sv
src/w3f_kernel.sv
src/window3x3_mean_median_filter.sv
verif/window3x3_mean_median_filter_tb.sv
